@@ hw/rtl/fpsr_pkg.sv @@
package fpsr_pkg;

    // request operations
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_PULL = 2'd1;
    localparam logic [1:0] OP_RESP = 2'd2;
    localparam logic [1:0] OP_TICK = 2'd3;

    // result kinds
    localparam logic [2:0] KIND_LINK   = 3'd0;
    localparam logic [2:0] KIND_ACK    = 3'd1;
    localparam logic [2:0] KIND_NAK    = 3'd2;
    localparam logic [2:0] KIND_WAIT   = 3'd3;
    localparam logic [2:0] KIND_REJECT = 3'd4;

    // frame and reply bytes
    localparam logic [7:0] BYTE_HEAD = 8'h11;
    localparam logic [7:0] BYTE_ACK  = 8'h06;
    localparam logic [7:0] BYTE_NAK  = 8'h15;
    localparam logic [7:0] BYTE_POLL = 8'hFF;

    // sender phases
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_HEAD  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_BODY  = 3'd3;
    localparam logic [2:0] PH_SUM   = 3'd4;
    localparam logic [2:0] PH_POLL  = 3'd5;
    localparam logic [2:0] PH_AWAIT = 3'd6;
    localparam logic [2:0] PH_WAIT  = 3'd7;

    // link byte source in the output stage
    localparam logic [1:0] SEL_FIX = 2'd0;
    localparam logic [1:0] SEL_MEM = 2'd1;
    localparam logic [1:0] SEL_SUM = 2'd2;

    // checksum update in the output stage
    localparam logic [1:0] SUM_KEEP = 2'd0;
    localparam logic [1:0] SUM_SET  = 2'd1;
    localparam logic [1:0] SUM_ADD  = 2'd2;

    // configuration registers
    localparam int         PADDR_W          = 3;
    localparam logic [7:0] WAIT_TICKS_RESET = 8'd200;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] link_byte;
        logic       poll_slot;
        logic [7:0] tries;
    } t_out_item;

    // result in flight between control and output stage
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] fix_byte;
        logic       poll_slot;
        logic [7:0] tries;
        logic [1:0] sel;
        logic [1:0] sum_op;
    } t_stage;

endpackage

@@ hw/rtl/framed_packet_sender_with_retry_core.sv @@
// Stop-and-wait frame sender. Load requests fill a payload memory; the byte
// marked last arms a frame, and each pull request returns the next frame byte
// (0x11, length, payload, 8-bit sum, 0xFF poll). A response request of 0x06
// finishes the packet, 0x15 resends at once, anything else waits wait_ticks
// tick requests and resends. One request is accepted every clock cycle unless
// the output stalls; a result passes the control stage register, where the
// payload memory is read, and then the output register, where the checksum is
// accumulated. The single memory read port serves one payload byte per cycle
// while the pipeline moves. The payload memory needs no clearing pass after
// reset. wait_ticks lives at byte address 0 of the register port.
module framed_packet_sender_with_retry_core
    import fpsr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_item,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output t_out_item          o_out_item,
    input  logic               i_out_stall,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [7:0]        r_wait_ticks;
    logic              s1_move;
    logic              s1_valid;
    t_stage            s1;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wait_ticks <= WAIT_TICKS_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            r_wait_ticks <= pwdata[7:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {24'd0, r_wait_ticks};

    fpsr_ctrl #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_item    (i_in_item),
        .o_in_stall   (o_in_stall),
        .i_wait_ticks (r_wait_ticks),
        .i_s1_move    (s1_move),
        .o_s1_valid   (s1_valid),
        .o_s1         (s1),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr)
    );

    fpsr_store #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    fpsr_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (s1_valid),
        .i_s1        (s1),
        .i_rd_data   (rd_data),
        .o_s1_move   (s1_move),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall)
    );

endmodule

@@ hw/rtl/fpsr_store.sv @@
module fpsr_store
    import fpsr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 128,
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [MAX_PAYLOAD];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds between reads so a stalled body byte keeps its value
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/fpsr_ctrl.sv @@
module fpsr_ctrl
    import fpsr_pkg::*;
#(
    parameter int MAX_PAYLOAD = 128,
    localparam int CNT_W  = $clog2(MAX_PAYLOAD + 1),
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  t_in_item          i_in_item,
    output logic              o_in_stall,
    input  logic [7:0]        i_wait_ticks,
    input  logic              i_s1_move,
    output logic              o_s1_valid,
    output t_stage            o_s1,
    output logic              o_wr_en,
    output logic [ADDR_W-1:0] o_wr_addr,
    output logic [7:0]        o_wr_data,
    output logic              o_rd_en,
    output logic [ADDR_W-1:0] o_rd_addr
);

    logic [2:0]       r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [7:0]       r_tries, n_tries;
    logic [7:0]       r_wait, n_wait;
    logic             r_s1_valid;
    t_stage           r_s1;
    t_stage           n_s1;
    logic             has_res;
    logic             in_fire;
    logic             full;

    assign o_in_stall = r_s1_valid && !i_s1_move;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign full       = (r_count == CNT_W'(MAX_PAYLOAD));

    always_comb begin
        n_phase   = r_phase;
        n_count   = r_count;
        n_idx     = r_idx;
        n_tries   = r_tries;
        n_wait    = r_wait;
        has_res   = 1'b0;
        o_wr_en   = 1'b0;
        o_rd_en   = 1'b0;
        n_s1.kind      = KIND_LINK;
        n_s1.fix_byte  = 8'h00;
        n_s1.poll_slot = 1'b0;
        n_s1.sel       = SEL_FIX;
        n_s1.sum_op    = SUM_KEEP;

        case (i_in_item.operation)
            OP_LOAD: begin
                if (r_phase != PH_IDLE) begin
                    has_res   = 1'b1;
                    n_s1.kind = KIND_REJECT;
                end else begin
                    if (full) begin
                        has_res   = 1'b1;
                        n_s1.kind = KIND_REJECT;
                    end else begin
                        o_wr_en = in_fire;
                        n_count = r_count + CNT_W'(1);
                    end
                    if (i_in_item.last) begin
                        n_phase = PH_HEAD;
                        n_idx   = '0;
                        n_tries = 8'd0;
                    end
                end
            end
            OP_PULL: begin
                case (r_phase)
                    PH_HEAD: begin
                        has_res       = 1'b1;
                        n_s1.fix_byte = BYTE_HEAD;
                        n_s1.sum_op   = SUM_SET;
                        n_phase       = PH_LEN;
                    end
                    PH_LEN: begin
                        has_res       = 1'b1;
                        n_s1.fix_byte = 8'(r_count);
                        n_s1.sum_op   = SUM_ADD;
                        n_idx         = '0;
                        n_phase       = (r_count == '0) ? PH_SUM : PH_BODY;
                    end
                    PH_BODY: begin
                        has_res     = 1'b1;
                        o_rd_en     = in_fire;
                        n_s1.sel    = SEL_MEM;
                        n_s1.sum_op = SUM_ADD;
                        n_idx       = r_idx + CNT_W'(1);
                        if ((r_idx + CNT_W'(1)) >= r_count) begin
                            n_phase = PH_SUM;
                        end
                    end
                    PH_SUM: begin
                        has_res  = 1'b1;
                        n_s1.sel = SEL_SUM;
                        n_phase  = PH_POLL;
                    end
                    PH_POLL: begin
                        has_res        = 1'b1;
                        n_s1.fix_byte  = BYTE_POLL;
                        n_s1.poll_slot = 1'b1;
                        if (r_tries != 8'hFF) begin
                            n_tries = r_tries + 8'd1;
                        end
                        n_phase = PH_AWAIT;
                    end
                    default: begin
                    end
                endcase
            end
            OP_RESP: begin
                if (r_phase == PH_AWAIT) begin
                    has_res = 1'b1;
                    if (i_in_item.data_byte == BYTE_ACK) begin
                        n_s1.kind = KIND_ACK;
                        n_phase   = PH_IDLE;
                        n_count   = '0;
                        n_idx     = '0;
                    end else if (i_in_item.data_byte == BYTE_NAK) begin
                        n_s1.kind = KIND_NAK;
                        n_phase   = PH_HEAD;
                        n_idx     = '0;
                    end else begin
                        n_s1.kind = KIND_WAIT;
                        n_phase   = PH_WAIT;
                        n_wait    = i_wait_ticks;
                    end
                end
            end
            default: begin
                if (r_phase == PH_WAIT) begin
                    if (r_wait <= 8'd1) begin
                        n_wait  = 8'd0;
                        n_phase = PH_HEAD;
                        n_idx   = '0;
                    end else begin
                        n_wait = r_wait - 8'd1;
                    end
                end
            end
        endcase
        n_s1.tries = n_tries;
    end

    // no write/read overlap on one entry: loads happen only while idle
    assign o_wr_addr = r_count[ADDR_W-1:0];
    assign o_wr_data = i_in_item.data_byte;
    assign o_rd_addr = r_idx[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_count    <= '0;
            r_idx      <= '0;
            r_tries    <= 8'd0;
            r_wait     <= 8'd0;
            r_s1_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_phase <= n_phase;
                r_count <= n_count;
                r_idx   <= n_idx;
                r_tries <= n_tries;
                r_wait  <= n_wait;
            end
            if (!o_in_stall) begin
                r_s1_valid <= in_fire && has_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1_valid = r_s1_valid;
    assign o_s1       = r_s1;

endmodule

@@ hw/rtl/fpsr_out.sv @@
module fpsr_out
    import fpsr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s1_valid,
    input  t_stage    i_s1,
    input  logic [7:0] i_rd_data,
    output logic      o_s1_move,
    output logic      o_out_valid,
    output t_out_item o_out_item,
    input  logic      i_out_stall
);

    logic       r_out_valid;
    t_out_item  r_out_item;
    logic [7:0] r_sum;
    logic [7:0] lb;

    assign o_s1_move = i_s1_valid && (!r_out_valid || !i_out_stall);

    always_comb begin
        case (i_s1.sel)
            SEL_MEM: lb = i_rd_data;
            SEL_SUM: lb = r_sum;
            default: lb = i_s1.fix_byte;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sum       <= 8'd0;
        end else begin
            if (o_s1_move) begin
                r_out_valid <= 1'b1;
                // checksum follows frame bytes in delivery order
                case (i_s1.sum_op)
                    SUM_SET: r_sum <= lb;
                    SUM_ADD: r_sum <= r_sum + lb;
                    default: r_sum <= r_sum;
                endcase
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_move) begin
            r_out_item.kind      <= i_s1.kind;
            r_out_item.link_byte <= lb;
            r_out_item.poll_slot <= i_s1.poll_slot;
            r_out_item.tries     <= i_s1.tries;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ hw/rtl/fpsr_checker.sv @@
module fpsr_checker
    import fpsr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_out_valid,
    input t_out_item o_out_item,
    input logic      i_out_stall
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.kind <= KIND_REJECT))
        else $error("result kind out of range");

    a_poll_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.poll_slot |->
            (o_out_item.kind == KIND_LINK) && (o_out_item.link_byte == BYTE_POLL))
        else $error("poll slot without poll byte");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind != KIND_LINK) |->
            (o_out_item.link_byte == 8'd0) && !o_out_item.poll_slot)
        else $error("status result carries link data");

endmodule

bind framed_packet_sender_with_retry_core fpsr_checker u_fpsr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);
